@@ rtl/egd_pkg.sv @@
// Shared types and constants for the Exp-Golomb stream decoder.
// Depends on nothing; egd_decoder and the top level import it.
package egd_pkg;

   // Longest zero prefix accepted before a prefix error is flagged
   localparam int MAX_PREFIX = 31;
   // Prefix counter and suffix-left counter width
   localparam int CNT_W      = $clog2(MAX_PREFIX + 1);
   // Suffix accumulator width (a suffix holds at most MAX_PREFIX bits)
   localparam int SUF_W      = MAX_PREFIX;
   // Raw code number width: 2^n - 1 + suffix < 2^(SUF_W+1)
   localparam int CODE_W     = SUF_W + 1;
   localparam int VALUE_W    = 33;

   // Input item: one byte of the bitstream
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      truncated;
      logic                      prefix_error;
      logic                      run_last;
   } rsp_type;

endpackage

@@ rtl/egd_fifo.sv @@
// Small register-based first-in first-out queue with a combinational head read.
// Generic on width and depth; no package dependency.
module egd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en, rd_en;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_en = push & ~full;
   assign rd_en = pop & ~empty;
   assign rdata = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/egd_decoder.sv @@
// Back end: bit-serial Exp-Golomb decoder, one bit of the head byte per cycle unless
// stalled, with a one-result holding stage that marks the last result of each byte.
// Depends on egd_pkg.
module egd_decoder (
   input  logic            clock,
   input  logic            reset,
   input  egd_pkg::req_type in_data,
   input  logic            in_empty,
   output logic            in_pop,
   input  logic            signed_mode,
   input  logic            out_full,
   output logic            out_push,
   output egd_pkg::rsp_type out_data
);
   import egd_pkg::*;

   // code state
   logic [CNT_W-1:0]  zero_cnt_ff, zero_cnt_in;
   logic              in_suffix_ff, in_suffix_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [SUF_W-1:0]  acc_ff, acc_in;
   logic [2:0]        pos_ff, pos_in;

   // holding stage for the newest result
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_done_ff, pend_done_in;
   logic [CODE_W-1:0] pend_code_ff, pend_code_in;
   logic              pend_trunc_ff, pend_trunc_in;
   logic              pend_perr_ff, pend_perr_in;

   logic              adv, step, end_byte, last_bit, cur_bit;
   logic [CNT_W-1:0]  left_m1;
   logic [SUF_W-1:0]  acc_set;
   logic              res_now, res_code, res_trunc, res_perr, clr;
   logic [CODE_W-1:0] code_num;
   logic              new_res;
   logic [VALUE_W-1:0] half_ext, map_base, mapped;

   // the whole back end advances only while the result queue has room
   assign adv      = ~out_full;
   assign step     = adv & ~in_empty;
   assign end_byte = step & (pos_ff == 3'd7);
   assign last_bit = in_data.final_byte & (pos_ff == 3'd7);
   assign cur_bit  = in_data.data_byte[3'd7 - pos_ff];
   assign in_pop   = end_byte;

   // suffix bit lands at its final weight, so an early end is already padded
   assign left_m1 = left_ff - 1'b1;
   assign acc_set = acc_ff | (SUF_W'(1) << left_m1);

   // one bit of decoding
   always_comb begin
      zero_cnt_in  = zero_cnt_ff;
      in_suffix_in = in_suffix_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      res_now      = 1'b0;
      res_code     = 1'b0;
      res_trunc    = 1'b0;
      res_perr     = 1'b0;
      clr          = 1'b0;
      if (step) begin
         pos_in = pos_ff + 1'b1;
         if (in_suffix_ff) begin
            left_in = left_m1;
            acc_in  = cur_bit ? acc_set : acc_ff;
            if (left_m1 == '0) begin
               res_now  = 1'b1;
               res_code = 1'b1;
               clr      = 1'b1;
            end else if (last_bit) begin
               res_now   = 1'b1;
               res_code  = 1'b1;
               res_trunc = 1'b1;
               clr       = 1'b1;
            end
         end else if (!cur_bit) begin
            if (zero_cnt_ff == CNT_W'(MAX_PREFIX)) begin
               // overlong prefix: flag it and start counting again
               res_now  = 1'b1;
               res_perr = 1'b1;
               clr      = 1'b1;
            end else begin
               zero_cnt_in = zero_cnt_ff + 1'b1;
               if (last_bit) begin
                  res_now   = 1'b1;
                  res_trunc = 1'b1;
                  clr       = 1'b1;
               end
            end
         end else begin
            if (zero_cnt_ff == '0) begin
               // lone one: whole code, value 0
               res_now = 1'b1;
               clr     = 1'b1;
            end else if (last_bit) begin
               res_now   = 1'b1;
               res_trunc = 1'b1;
               clr       = 1'b1;
            end else begin
               in_suffix_in = 1'b1;
               left_in      = zero_cnt_ff;
               acc_in       = '0;
            end
         end
         if (clr || last_bit) begin
            zero_cnt_in  = '0;
            in_suffix_in = 1'b0;
            left_in      = '0;
            acc_in       = '0;
         end
      end
   end

   // code number 2^n - 1 + suffix; suffix < 2^n so the add is an OR then a decrement
   always_comb begin
      code_num = '0;
      if (res_code) begin
         code_num = ((CODE_W'(1) << zero_cnt_ff)
                     | {1'b0, (cur_bit ? acc_set : acc_ff)}) - 1'b1;
      end
   end

   assign new_res = step & res_now;

   // holding stage: a result leaves once it is known whether it ends its byte
   assign out_push = adv & pend_valid_ff & (pend_done_ff | new_res | end_byte);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_done_in  = pend_done_ff;
      pend_code_in  = pend_code_ff;
      pend_trunc_in = pend_trunc_ff;
      pend_perr_in  = pend_perr_ff;
      if (new_res) begin
         pend_valid_in = 1'b1;
         pend_done_in  = end_byte;
         pend_code_in  = code_num;
         pend_trunc_in = res_trunc;
         pend_perr_in  = res_perr;
      end else if (out_push) begin
         pend_valid_in = 1'b0;
         pend_done_in  = 1'b0;
      end
   end

   // signed mapping: odd k -> (k+1)/2, even k -> -(k/2); both are base + 1
   assign half_ext = VALUE_W'(pend_code_ff[CODE_W-1:1]);
   assign map_base = pend_code_ff[0] ? half_ext : ~half_ext;
   assign mapped   = map_base + 1'b1;

   always_comb begin
      out_data.value        = signed_mode ? mapped : VALUE_W'(pend_code_ff);
      out_data.truncated    = pend_trunc_ff;
      out_data.prefix_error = pend_perr_ff;
      out_data.run_last     = pend_done_ff | ~new_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_cnt_ff   <= '0;
         in_suffix_ff  <= 1'b0;
         left_ff       <= '0;
         acc_ff        <= '0;
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_done_ff  <= 1'b0;
      end else begin
         zero_cnt_ff   <= zero_cnt_in;
         in_suffix_ff  <= in_suffix_in;
         left_ff       <= left_in;
         acc_ff        <= acc_in;
         pos_ff        <= pos_in;
         pend_valid_ff <= pend_valid_in;
         pend_done_ff  <= pend_done_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      pend_code_ff  <= pend_code_in;
      pend_trunc_ff <= pend_trunc_in;
      pend_perr_ff  <= pend_perr_in;
   end

endmodule

@@ rtl/exp_golomb_stream_decoder.sv @@
// Channel   Handshake              Payload
// req_      push / full            req_data  (data_byte, final_byte)
// rsp_      empty / pop            rsp_data  (value, truncated, prefix_error, run_last)
// csr_      valid / ready          csr_data  (signed_mode)
//
// The bit-serial decoder takes each byte one bit per cycle while not stalled,
// whatever number of results (zero to eight) it yields. A result waits in a
// one-entry stage until the next result or the end of its byte settles run_last,
// and only then enters the result queue. Bytes queue in front of the decoder and
// results behind it, so either side may stall on its own; a full result queue
// freezes the decoder. Reset is synchronous and needs no sweep.
// Top level; depends on egd_pkg, egd_fifo and egd_decoder.
module exp_golomb_stream_decoder #(
   parameter int IN_DEPTH  = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  egd_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output egd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import egd_pkg::*;

   logic    signed_mode_ff, signed_mode_in;
   req_type head_data;
   logic    head_empty, head_pop;
   logic    res_push, res_full;
   rsp_type res_data;

   // configuration register
   assign csr_ready      = 1'b1;
   assign signed_mode_in = (csr_valid & csr_ready) ? csr_data : signed_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   // front: byte queue
   egd_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (IN_DEPTH)
   ) u_req_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (req_data),
      .full  (req_full),
      .pop   (head_pop),
      .rdata (head_data),
      .empty (head_empty)
   );

   // back: bit-serial decoder
   egd_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .in_data     (head_data),
      .in_empty    (head_empty),
      .in_pop      (head_pop),
      .signed_mode (signed_mode_ff),
      .out_full    (res_full),
      .out_push    (res_push),
      .out_data    (res_data)
   );

   // result queue
   egd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule
